// ----- hdl/fcd_pkg.sv -----
`timescale 1ns / 1ps

package fcd_pkg;

    // Byte codes of the compacted flux stream.
    localparam logic [7:0] CODE_SHORT_MAX = 8'h07;
    localparam logic [7:0] CODE_SKIP_BASE = 8'h08;
    localparam logic [7:0] CODE_SKIP_MAX  = 8'h0A;
    localparam logic [7:0] CODE_OVERFLOW  = 8'h0B;
    localparam logic [7:0] CODE_LONG      = 8'h0C;
    localparam logic [7:0] CODE_STRAY     = 8'h0D;

    localparam int unsigned SCALE_W   = 32;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned NS_W      = 40;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned FRAC_BITS = 24;

    // Reset value of the Q8.24 nanoseconds-per-sample register.
    localparam logic [SCALE_W-1:0] NS_PER_SAMPLE_RESET = 32'd698238874;

    // One half in Q.24, added before the fractional bits are dropped.
    localparam logic [PROD_W-1:0] ROUND_HALF = 64'h0000_0000_0080_0000;

endpackage

// ----- hdl/flux_cell_decoder.sv -----
`timescale 1ns / 1ps

// Flux cell decoder.
// The input channel (i_in_valid / o_in_ready) takes one byte of the compacted
// flux stream per transfer, together with a block-start flag that clears the
// running totals and any partly read count before that byte is decoded.
// The output channel (o_out_valid / i_out_ready) gives one transfer per
// completed count: the raw count in sample clocks and the interval in
// nanoseconds, rounded against the running position so that no error builds up.
// The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
// Q8.24 nanoseconds-per-sample scale; it is always ready.
// A byte is accepted in every cycle while o_in_ready is high. A result is registered
// in turn by the stages for decode, 32x32 multiply, rounding add, then the
// interval subtraction into the output register.
// Bytes that do not complete a count give no result.
// After reset the pipeline is empty, the decoder state is cleared and the scale
// holds its default. When the receiver stalls, the output register holds its
// result and the stall propagates back stage by stage; o_in_ready falls only
// once every stage holds a result.
module flux_cell_decoder
    import fcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_block_start,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [31:0]         o_interval_ns,
    output logic [31:0]         o_cell_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SCALE_W-1:0]  i_cfg_data
);

    logic [SCALE_W-1:0] r_scale;

    // Decoder state.
    logic [1:0]         r_pend, n_pend;
    logic               r_is_count, n_is_count;
    logic [7:0]         r_part, n_part;
    logic [15:0]        r_ovf, n_ovf;
    logic [COUNT_W-1:0] r_samples, n_samples;
    logic               r_clr_pend, n_clr_pend;

    logic               n_emit;
    logic [15:0]        n_raw;
    logic [COUNT_W-1:0] n_count;

    logic [1:0]         w_pend;
    logic               w_is_count;
    logic [7:0]         w_part;
    logic [15:0]        w_ovf;
    logic [COUNT_W-1:0] w_samples;
    logic [1:0]         w_pend_dec;
    logic [7:0]         w_skip;

    // Pipeline stages.
    logic               r_a_vld, r_b_vld, r_c_vld, r_o_vld;
    logic [COUNT_W-1:0] r_a_cnt, r_b_cnt, r_c_cnt, r_o_cnt;
    logic               r_a_clr, r_b_clr, r_c_clr;
    logic [COUNT_W-1:0] r_a_samples;
    logic [PROD_W-1:0]  r_b_prod;
    logic [NS_W-1:0]    r_c_ns;
    logic [31:0]        r_o_int;
    logic [NS_W-1:0]    r_running_ns;

    logic               w_en_a, w_en_b, w_en_c, w_en_o;
    logic               w_in_xfer;
    logic [PROD_W-1:0]  w_round;
    logic [NS_W-1:0]    w_prev_ns;
    logic [NS_W-1:0]    w_diff;

    assign w_en_o    = !r_o_vld || i_out_ready;
    assign w_en_c    = !r_c_vld || w_en_o;
    assign w_en_b    = !r_b_vld || w_en_c;
    assign w_en_a    = !r_a_vld || w_en_b;
    assign w_in_xfer = i_in_valid && w_en_a;

    assign o_in_ready    = w_en_a;
    assign o_out_valid   = r_o_vld;
    assign o_interval_ns = r_o_int;
    assign o_cell_count  = r_o_cnt;
    assign o_cfg_ready   = 1'b1;

    // State as seen by this byte, after an optional block-start clear.
    assign w_pend     = i_block_start ? 2'd0 : r_pend;
    assign w_is_count = i_block_start ? 1'b0 : r_is_count;
    assign w_part     = i_block_start ? 8'd0 : r_part;
    assign w_ovf      = i_block_start ? 16'd0 : r_ovf;
    assign w_samples  = i_block_start ? '0 : r_samples;
    assign w_pend_dec = w_pend - 2'd1;
    assign w_skip     = i_data_byte - CODE_SKIP_BASE;

    always_comb begin
        n_pend     = w_pend;
        n_is_count = w_is_count;
        n_part     = w_part;
        n_ovf      = w_ovf;
        n_emit     = 1'b0;
        n_raw      = {8'd0, i_data_byte};
        if (w_pend != 2'd0) begin
            n_pend = w_pend_dec;
            if (w_is_count) begin
                if (w_pend_dec != 2'd0) begin
                    n_part = i_data_byte;
                end else begin
                    n_is_count = 1'b0;
                    n_emit     = 1'b1;
                    n_raw      = {w_part, i_data_byte};
                end
            end
        end else begin
            case (i_data_byte) inside
                [8'h00:CODE_SHORT_MAX]: begin
                    n_part     = i_data_byte;
                    n_pend     = 2'd1;
                    n_is_count = 1'b1;
                end
                [CODE_SKIP_BASE:CODE_SKIP_MAX]: begin
                    n_pend     = w_skip[1:0];
                    n_is_count = 1'b0;
                end
                CODE_OVERFLOW: begin
                    n_ovf = w_ovf + 16'd1;
                end
                CODE_LONG: begin
                    n_part     = 8'd0;
                    n_pend     = 2'd2;
                    n_is_count = 1'b1;
                end
                CODE_STRAY: begin
                end
                default: begin
                    n_emit = 1'b1;
                end
            endcase
        end
        // The overflow additions are multiples of 65536, so only their upper half is kept.
        n_count   = {16'd0, n_raw} + {w_ovf, 16'd0};
        n_samples = w_samples;
        if (n_emit) begin
            n_ovf     = 16'd0;
            n_samples = w_samples + n_count;
        end
        // A block start that gives no result is carried to the next result,
        // which must then measure its interval from a position of zero.
        n_clr_pend = (i_block_start || r_clr_pend) && !n_emit;
    end

    assign w_round   = r_b_prod + ROUND_HALF;
    assign w_prev_ns = r_c_clr ? '0 : r_running_ns;
    assign w_diff    = r_c_ns - w_prev_ns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= NS_PER_SAMPLE_RESET;
            r_pend       <= 2'd0;
            r_is_count   <= 1'b0;
            r_part       <= 8'd0;
            r_ovf        <= 16'd0;
            r_samples    <= '0;
            r_clr_pend   <= 1'b0;
            r_running_ns <= '0;
            r_a_vld      <= 1'b0;
            r_b_vld      <= 1'b0;
            r_c_vld      <= 1'b0;
            r_o_vld      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
            if (w_in_xfer) begin
                r_pend     <= n_pend;
                r_is_count <= n_is_count;
                r_part     <= n_part;
                r_ovf      <= n_ovf;
                r_samples  <= n_samples;
                r_clr_pend <= n_clr_pend;
            end
            if (w_en_a) begin
                r_a_vld <= w_in_xfer && n_emit;
            end
            if (w_en_b) begin
                r_b_vld <= r_a_vld;
            end
            if (w_en_c) begin
                r_c_vld <= r_b_vld;
            end
            if (w_en_o) begin
                r_o_vld <= r_c_vld;
                if (r_c_vld) begin
                    r_running_ns <= r_c_ns;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_cnt     <= n_count;
            r_a_samples <= n_samples;
            r_a_clr     <= i_block_start || r_clr_pend;
        end
        if (w_en_b) begin
            r_b_prod <= PROD_W'(r_scale) * PROD_W'(r_a_samples);
            r_b_cnt  <= r_a_cnt;
            r_b_clr  <= r_a_clr;
        end
        if (w_en_c) begin
            r_c_ns  <= w_round[PROD_W-1:FRAC_BITS];
            r_c_cnt <= r_b_cnt;
            r_c_clr <= r_b_clr;
        end
        if (w_en_o) begin
            r_o_int <= w_diff[31:0];
            r_o_cnt <= r_c_cnt;
        end
    end

endmodule

// ----- hdl/fcd_checker.sv -----
`timescale 1ns / 1ps

module fcd_checker
    import fcd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic [7:0]          i_data_byte,
    input logic                i_block_start,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [31:0]         o_interval_ns,
    input logic [31:0]         o_cell_count,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [SCALE_W-1:0]  i_cfg_data
);

    // A result waiting on a stalled receiver keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_interval_ns) && $stable(o_cell_count))
        else $error("stalled result changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    // With the output free or draining, no stage can be blocking the input.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled while output is free");

    // The scale register is always writeable.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind flux_cell_decoder fcd_checker u_fcd_checker (.*);

// ----- tb/sv/tb_flux_cell_decoder.sv -----
`timescale 1ns / 1ps

module tb_flux_cell_decoder;
    import fcd_pkg::*;

    localparam int unsigned RUN_LIMIT    = 600000;
    localparam int          PHASE_BYTES  = 155;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [31:0] CARRY_STEP   = 32'h0001_0000;
    localparam logic [31:0] SCALE_ONE    = 32'h0100_0000;

    typedef struct packed {
        logic [31:0] interval_ns;
        logic [31:0] cell_count;
    } cell_t;

    // One row of the directed plan. Where typed is set, the expected cell is
    // taken from the row rather than from the decoder model.
    typedef struct packed {
        logic [7:0]  data;
        logic        blk;
        logic        typed;
        logic [31:0] interval_ns;
        logic [31:0] cell_count;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        in_byte = '0;
    logic              in_blk = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [31:0]       out_interval;
    logic [31:0]       out_count;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SCALE_W-1:0] cfg_data = '0;

    // Decoder model state.
    logic [31:0] ns_scale;
    logic [1:0]  bytes_left;
    logic        left_is_count;
    logic [15:0] high_part;
    logic [31:0] carry_acc;
    logic [31:0] sample_total;
    logic [39:0] pos_ns;

    cell_t       pending_cells [$];
    plan_row_t   plan [0:26];
    int          errors = 0;
    int          bytes_sent = 0;
    int          cells_seen = 0;
    int          scales_used = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;
    bit          start_next = 1'b0;

    flux_cell_decoder u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_data_byte   (in_byte),
        .i_block_start (in_blk),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_interval_ns (out_interval),
        .o_cell_count  (out_count),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Timed out after %0d cycles with %0d cells outstanding",
                     cycle_count, pending_cells.size());
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver stalls in roughly one cycle in five, except while calm.
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 20);
    end

    task automatic report_fault(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    // Outputs are settled at the falling edge, so a transfer seen here takes
    // place at the next rising edge.
    always @(negedge clk) begin : check_cell
        cell_t want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            cells_seen++;
            if (pending_cells.size() == 0) begin
                report_fault($sformatf("Unexpected cell: interval %h count %h",
                                       out_interval, out_count));
            end else begin
                want = pending_cells.pop_front();
                if (out_interval !== want.interval_ns)
                    report_fault($sformatf("Interval mismatch: expected %h, got %h",
                                           want.interval_ns, out_interval));
                if (out_count !== want.cell_count)
                    report_fault($sformatf("Count mismatch: expected %h, got %h",
                                           want.cell_count, out_count));
            end
        end
    end

    // Decodes one stream byte into the model state. Returns 1 when a count
    // completes, with the rounded interval and the raw count.
    function automatic bit decode_flux_byte(input logic [7:0] b, input logic blk,
                                            output logic [31:0] iv,
                                            output logic [31:0] cnt);
        logic [31:0] raw;
        logic [63:0] prod;
        logic [39:0] new_ns;
        bit          done;
        raw  = '0;
        done = 1'b0;
        iv   = '0;
        cnt  = '0;
        if (blk) begin
            bytes_left    = '0;
            left_is_count = 1'b0;
            high_part     = '0;
            carry_acc     = '0;
            sample_total  = '0;
            pos_ns        = '0;
        end
        if (bytes_left != 0) begin
            bytes_left = bytes_left - 2'd1;
            if (left_is_count) begin
                if (bytes_left != 0) begin
                    high_part = {8'h00, b};
                end else begin
                    left_is_count = 1'b0;
                    raw  = {16'h0000, high_part[7:0], b};
                    done = 1'b1;
                end
            end
        end else if (b <= CODE_SHORT_MAX) begin
            high_part     = {8'h00, b};
            bytes_left    = 2'd1;
            left_is_count = 1'b1;
        end else if (b <= CODE_SKIP_MAX) begin
            bytes_left    = 2'(b - CODE_SKIP_BASE);
            left_is_count = 1'b0;
        end else if (b == CODE_OVERFLOW) begin
            carry_acc = carry_acc + CARRY_STEP;
        end else if (b == CODE_LONG) begin
            high_part     = '0;
            bytes_left    = 2'd2;
            left_is_count = 1'b1;
        end else if (b != CODE_STRAY) begin
            raw  = {24'h000000, b};
            done = 1'b1;
        end
        if (done) begin
            cnt          = raw + carry_acc;
            carry_acc    = '0;
            sample_total = sample_total + cnt;
            prod         = {32'h0, ns_scale} * {32'h0, sample_total};
            new_ns       = 40'((prod + ROUND_HALF) >> FRAC_BITS);
            iv           = 32'(new_ns - pos_ns);
            pos_ns       = new_ns;
        end
        return done;
    endfunction

    // Presents one byte, holds it until the transfer, then records what it
    // should produce.
    task automatic push_byte(input logic [7:0] b, input logic blk,
                             input bit typed, input cell_t typed_cell);
        logic        rdy;
        logic [31:0] iv;
        logic [31:0] cnt;
        bit          got;
        if (!calm && $urandom_range(99) < 20) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_blk   <= blk;
        do begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end while (!rdy);
        got = decode_flux_byte(b, blk, iv, cnt);
        if (typed)
            pending_cells.push_back(typed_cell);
        else if (got)
            pending_cells.push_back('{interval_ns: iv, cell_count: cnt});
        bytes_sent++;
    endtask

    task automatic push_model(input logic [7:0] b, input logic blk);
        push_byte(b, blk, 1'b0, '0);
    endtask

    task automatic drain_cells();
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only written once the decoder has gone quiet.
    task automatic write_scale(input logic [31:0] value);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        ns_scale = value;
        scales_used++;
    endtask

    // One well-formed stream element with random content, or now and then
    // noise or a count or carry cut short by a block start.
    task automatic push_token();
        int   r;
        int   k;
        logic blk;
        r   = $urandom_range(99);
        blk = start_next || ($urandom_range(99) < 3);
        start_next = 1'b0;
        if (r < 10) begin
            push_model(8'($urandom_range(255)), blk);
        end else if (r < 40) begin
            push_model(8'($urandom_range(255, 14)), blk);
        end else if (r < 55) begin
            push_model(8'($urandom_range(7)), blk);
            push_model(8'($urandom_range(255)), 1'b0);
        end else if (r < 65) begin
            push_model(CODE_LONG, blk);
            push_model(8'($urandom_range(255)), 1'b0);
            push_model(8'($urandom_range(255)), 1'b0);
        end else if (r < 75) begin
            push_model(CODE_OVERFLOW, blk);
            repeat ($urandom_range(2)) push_model(CODE_OVERFLOW, 1'b0);
            push_model(8'($urandom_range(255, 14)), 1'b0);
        end else if (r < 85) begin
            k = $urandom_range(2);
            push_model(CODE_SKIP_BASE + 8'(k), blk);
            repeat (k) push_model(8'($urandom_range(255)), 1'b0);
        end else if (r < 88) begin
            push_model(CODE_STRAY, blk);
        end else if (r < 95) begin
            // A count or a carry left unfinished; the next element opens a block.
            k = $urandom_range(2);
            if (k == 0) begin
                push_model(8'($urandom_range(7)), blk);
            end else if (k == 1) begin
                push_model(CODE_LONG, blk);
                if ($urandom_range(1) == 1)
                    push_model(8'($urandom_range(255)), 1'b0);
            end else begin
                push_model(CODE_OVERFLOW, blk);
            end
            start_next = 1'b1;
        end else begin
            // A long carry run pushes the running position well up.
            push_model(CODE_OVERFLOW, blk);
            repeat ($urandom_range(200, 20)) push_model(CODE_OVERFLOW, 1'b0);
            push_model(8'($urandom_range(255)), 1'b0);
            push_model(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial begin : run
        int          i;
        int          p;
        int          phase_start;
        logic [31:0] next_scale;

        ns_scale      = NS_PER_SAMPLE_RESET;
        bytes_left    = '0;
        left_is_count = 1'b0;
        high_part     = '0;
        carry_acc     = '0;
        sample_total  = '0;
        pos_ns        = '0;

        // With a scale of exactly one nanosecond per sample the interval equals
        // the count, so most expectations can be written straight in.
        plan = '{
            '{8'h0E,           1'b1, 1'b1, 32'd14,       32'd14},
            '{8'hFF,           1'b0, 1'b1, 32'd255,      32'd255},
            '{8'h00,           1'b0, 1'b0, 32'd0,        32'd0},
            '{8'h00,           1'b0, 1'b1, 32'd0,        32'd0},
            '{CODE_SHORT_MAX,  1'b0, 1'b0, 32'd0,        32'd0},
            '{8'hFF,           1'b0, 1'b1, 32'h0000_07FF, 32'h0000_07FF},
            '{CODE_LONG,       1'b0, 1'b0, 32'd0,        32'd0},
            '{8'hFF,           1'b0, 1'b0, 32'd0,        32'd0},
            '{8'hFF,           1'b0, 1'b1, 32'h0000_FFFF, 32'h0000_FFFF},
            '{CODE_OVERFLOW,   1'b0, 1'b0, 32'd0,        32'd0},
            '{CODE_OVERFLOW,   1'b0, 1'b0, 32'd0,        32'd0},
            '{8'h0E,           1'b0, 1'b1, 32'h0002_000E, 32'h0002_000E},
            '{CODE_SKIP_BASE,  1'b0, 1'b0, 32'd0,        32'd0},
            '{CODE_SKIP_BASE + 8'd1, 1'b0, 1'b0, 32'd0,  32'd0},
            '{8'h0E,           1'b0, 1'b0, 32'd0,        32'd0},
            '{CODE_SKIP_MAX,   1'b0, 1'b0, 32'd0,        32'd0},
            '{CODE_LONG,       1'b0, 1'b0, 32'd0,        32'd0},
            '{8'hFF,           1'b0, 1'b0, 32'd0,        32'd0},
            '{CODE_STRAY,      1'b0, 1'b0, 32'd0,        32'd0},
            '{8'h10,           1'b0, 1'b1, 32'd16,       32'd16},
            '{8'h05,           1'b0, 1'b0, 32'd0,        32'd0},
            '{8'h20,           1'b1, 1'b1, 32'd32,       32'd32},
            '{CODE_LONG,       1'b0, 1'b0, 32'd0,        32'd0},
            '{8'h00,           1'b0, 1'b0, 32'd0,        32'd0},
            '{8'h00,           1'b0, 1'b1, 32'd0,        32'd0},
            '{CODE_OVERFLOW,   1'b0, 1'b0, 32'd0,        32'd0},
            '{8'h0E,           1'b1, 1'b1, 32'd14,       32'd14}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_scale(SCALE_ONE);
        for (i = 0; i < 27; i++)
            push_byte(plan[i].data, plan[i].blk, plan[i].typed,
                      {plan[i].interval_ns, plan[i].cell_count});
        drain_cells();

        for (p = 0; p < 6; p++) begin
            case (p)
                0:       next_scale = NS_PER_SAMPLE_RESET;
                1:       next_scale = 32'h0000_0000;
                3:       next_scale = 32'h0000_0001;
                4:       next_scale = 32'hFFFF_FFFF;
                default: next_scale = $urandom;
            endcase
            write_scale(next_scale);
            // The full-scale phase runs flat out, with neither side idling.
            calm = (p == 4);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                push_token();
            drain_cells();
            calm = 1'b0;
        end

        if (pending_cells.size() != 0)
            report_fault($sformatf("%0d expected cells never arrived",
                                   pending_cells.size()));
        $display("Decoded %0d stream bytes into %0d cells under %0d scale settings,",
                 bytes_sent, cells_seen, scales_used);
        $display("including block starts in mid-count and a phase with no idling; %0d faults.",
                 errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/fcd_pkg.sv
hdl/flux_cell_decoder.sv
hdl/fcd_checker.sv
tb/sv/tb_flux_cell_decoder.sv
